/* rtl/hslrgb_pkg.sv */
`timescale 1ns / 1ps

package hslrgb_pkg;

	// Field widths of the pixel beats.
	localparam int HUE_W = 13;
	localparam int SAT_W = 11;
	localparam int LIT_W = 11;
	localparam int CH_W  = 8;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;

	localparam int NUM_LANES  = 3;
	localparam int NUM_STAGES = 7;

	// Hue is in 1/16 degree, saturation and lightness in 1/16 percent.
	localparam logic [HUE_W-1:0] HUE_FULL   = 13'd5760;
	localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
	localparam logic [HUE_W-1:0] HUE_SEC2   = 13'd1920;
	localparam logic [HUE_W-1:0] HUE_SEC3   = 13'd2880;
	localparam logic [HUE_W-1:0] HUE_SEC4   = 13'd3840;
	localparam logic [HUE_W-1:0] HUE_SEC5   = 13'd4800;
	localparam logic [SAT_W-1:0] PCT_FULL   = 11'd1600;
	localparam logic [11:0]      PCT_DOUBLE = 12'd3200;

	// All channel values are kept exactly over 1600 * 1600 * 960.
	localparam logic [31:0] LIT_SCALE    = 32'd1536000;
	localparam logic [31:0] SECTOR_SCALE = 32'd960;
	localparam logic [31:0] HALF_SECTOR  = 32'd480;

	// 255 * n / 2457600000 rounded: add half the divisor, drop 2^18, then divide by 9375.
	localparam logic [39:0] CH_SCALE   = 40'd255;
	localparam logic [39:0] ROUND_HALF = 40'd1228800000;
	localparam int          PRE_SHIFT  = 18;
	localparam logic [21:0] CH_DIV     = 22'd9375;
	localparam logic [44:0] CH_RECIP   = 45'd7330077;
	localparam int          RECIP_SHIFT = 36;
	localparam logic [8:0]  CH_MAX     = 9'd255;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage

/* rtl/hsl_to_rgb_pixel_convert_unit.sv */
`timescale 1ns / 1ps

// HSL to RGB pixel converter. One pixel beat enters on the s_ side with hue in
// 1/16 degree (reduced modulo 360 degrees), saturation and lightness in 1/16
// percent (saturated at 100 percent), and leaves on the m_ side as rounded 8-bit
// red, green and blue. The datapath is a seven-stage pipeline that takes one
// pixel every clock cycle while m_tready does not hold it back; the stage count
// is set by the chroma and hue multipliers and the constant-reciprocal division
// of each channel. Each stage holds its beat while the one after it is full and
// cannot move on, so back-pressure on m_tready stalls only as far back as the
// pipeline is occupied and empty stages keep filling.
module hsl_to_rgb_pixel_convert_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// hue [12:0], saturation [23:13], lightness [34:24], zeros [39:35]
	input  logic [hslrgb_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// red [7:0], green [15:8], blue [23:16]
	output logic [hslrgb_pkg::M_TDATA_W-1:0]  m_tdata
);
	import hslrgb_pkg::*;

	logic [NUM_STAGES-1:0] stg_vld_q;
	logic [NUM_STAGES-1:0] adv;

	// Stage 1: input reduction.
	logic [HUE_W-1:0] hue_in;
	logic [SAT_W-1:0] sat_in;
	logic [LIT_W-1:0] lit_in;
	logic [HUE_W-1:0] hue_red;
	logic [SAT_W-1:0] sat_clip;
	logic [LIT_W-1:0] lit_clip;
	logic [11:0]      two_l;
	logic [11:0]      cl_full;

	logic [HUE_W-1:0] hue_s1;
	logic [SAT_W-1:0] sat_s1;
	logic [LIT_W-1:0] lit_s1;
	logic [10:0]      cl_s1;

	// Stage 2: chroma, hue triangle and sector.
	sector_t          sec_nx;
	logic [HUE_W-1:0] hue_base;
	logic [10:0]      hm;
	logic [10:0]      tri_full;

	logic [21:0]      cn_s2;
	logic [9:0]       tri_s2;
	sector_t          sec_s2;
	logic [31:0]      lt_s2;

	// Stage 3: scaled components.
	logic [31:0]      cx_s3;
	logic [31:0]      c2_s3;
	logic [31:0]      mh_s3;
	sector_t          sec_s3;

	// Stages 4 to 7: per-channel sum, scale, divide, correct.
	logic [31:0]      comp   [NUM_LANES];
	logic [31:0]      n2_s4  [NUM_LANES];
	logic [21:0]      u_s5   [NUM_LANES];
	logic [44:0]      prod6  [NUM_LANES];
	logic [8:0]       q0_s6  [NUM_LANES];
	logic [21:0]      u_s6   [NUM_LANES];
	logic [21:0]      rem7   [NUM_LANES];
	logic [8:0]       q7     [NUM_LANES];
	logic [CH_W-1:0]  ch_s7  [NUM_LANES];

	// A stage may load when it is empty or its beat moves on this cycle.
	always_comb begin
		adv[NUM_STAGES-1] = !stg_vld_q[NUM_STAGES-1] || m_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !stg_vld_q[k] || adv[k+1];
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = stg_vld_q[NUM_STAGES-1];
	assign m_tdata  = {ch_s7[2], ch_s7[1], ch_s7[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (adv[0]) begin
				stg_vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					stg_vld_q[k] <= stg_vld_q[k-1];
				end
			end
		end
	end

	// Stage 1
	always_comb begin
		hue_in   = s_tdata[HUE_W-1:0];
		sat_in   = s_tdata[HUE_W +: SAT_W];
		lit_in   = s_tdata[HUE_W+SAT_W +: LIT_W];
		hue_red  = (hue_in >= HUE_FULL) ? hue_in - HUE_FULL : hue_in;
		sat_clip = (sat_in > PCT_FULL) ? PCT_FULL : sat_in;
		lit_clip = (lit_in > PCT_FULL) ? PCT_FULL : lit_in;
		two_l    = {lit_clip, 1'b0};
		// 1600 - |2L - 1600| folds into one subtract.
		cl_full  = (two_l >= {1'b0, PCT_FULL}) ? PCT_DOUBLE - two_l : two_l;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			hue_s1 <= hue_red;
			sat_s1 <= sat_clip;
			lit_s1 <= lit_clip;
			cl_s1  <= cl_full[10:0];
		end
	end

	// Stage 2
	always_comb begin
		if (hue_s1 >= HUE_SEC5) begin
			sec_nx   = SEC_MAG_RED;
			hue_base = HUE_SEC4;
		end else if (hue_s1 >= HUE_SEC4) begin
			sec_nx   = SEC_BLU_MAG;
			hue_base = HUE_SEC4;
		end else if (hue_s1 >= HUE_SEC3) begin
			sec_nx   = SEC_CYN_BLU;
			hue_base = HUE_SEC2;
		end else if (hue_s1 >= HUE_SEC2) begin
			sec_nx   = SEC_GRN_CYN;
			hue_base = HUE_SEC2;
		end else if (hue_s1 >= HUE_SECTOR) begin
			sec_nx   = SEC_YEL_GRN;
			hue_base = '0;
		end else begin
			sec_nx   = SEC_RED_YEL;
			hue_base = '0;
		end
		hm       = 11'(hue_s1 - hue_base);
		tri_full = (hm >= HUE_SECTOR[10:0]) ? HUE_SEC2[10:0] - hm : hm;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cn_s2  <= 22'(cl_s1) * 22'(sat_s1);
			tri_s2 <= tri_full[9:0];
			sec_s2 <= sec_nx;
			lt_s2  <= 32'(lit_s1) * LIT_SCALE;
		end
	end

	// Stage 3: the offset never goes negative, since L * 1600 >= chroma / 2.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			cx_s3  <= 32'(cn_s2) * 32'(tri_s2);
			c2_s3  <= 32'(cn_s2) * SECTOR_SCALE;
			mh_s3  <= lt_s2 - 32'(cn_s2) * HALF_SECTOR;
			sec_s3 <= sec_s2;
		end
	end

	// Stage 4: component order by sector.
	always_comb begin
		case (sec_s3)
			SEC_RED_YEL: begin
				comp[0] = c2_s3;
				comp[1] = cx_s3;
				comp[2] = '0;
			end
			SEC_YEL_GRN: begin
				comp[0] = cx_s3;
				comp[1] = c2_s3;
				comp[2] = '0;
			end
			SEC_GRN_CYN: begin
				comp[0] = '0;
				comp[1] = c2_s3;
				comp[2] = cx_s3;
			end
			SEC_CYN_BLU: begin
				comp[0] = '0;
				comp[1] = cx_s3;
				comp[2] = c2_s3;
			end
			SEC_BLU_MAG: begin
				comp[0] = cx_s3;
				comp[1] = '0;
				comp[2] = c2_s3;
			end
			default: begin
				comp[0] = c2_s3;
				comp[1] = '0;
				comp[2] = cx_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				n2_s4[i] <= comp[i] + mh_s3;
			end
		end
	end

	// Stage 5: scale by 255, add half the divisor and drop the power of two.
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				u_s5[i] <= 22'((40'(n2_s4[i]) * CH_SCALE + ROUND_HALF) >> PRE_SHIFT);
			end
		end
	end

	// Stage 6: reciprocal estimate, low by at most one.
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			prod6[i] = 45'(u_s5[i]) * CH_RECIP;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				q0_s6[i] <= prod6[i][RECIP_SHIFT +: 9];
				u_s6[i]  <= u_s5[i];
			end
		end
	end

	// Stage 7: correct the estimate and clamp.
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			rem7[i] = u_s6[i] - 22'(q0_s6[i]) * CH_DIV;
			q7[i]   = (rem7[i] >= CH_DIV) ? q0_s6[i] + 9'd1 : q0_s6[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				ch_s7[i] <= (q7[i] > CH_MAX) ? CH_MAX[CH_W-1:0] : q7[i][CH_W-1:0];
			end
		end
	end

endmodule
